### hw/rtl/sms_pkg.sv
package sms_pkg;

    // Matrix geometry
    localparam int ROWS  = 10;
    localparam int COLS  = 16;
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = 32;
    localparam int LINW  = 8;

    // Action codes
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_DMAX   = 2'd3;

    typedef struct packed {
        logic [1:0]           action;
        logic [3:0]           row;
        logic [3:0]           column;
        logic signed [DW-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0] result_value;
        logic                 hit;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_write;
        logic finish_lookup;
        logic scan_start;
        logic scan_step;
        logic scan_drain;
        logic dmax_finish;
        logic push_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       scan_last;
        logic       out_free;
    } t_status;

endpackage

### hw/rtl/sms_ram.sv
module sms_ram #(
    parameter int W = 32,
    parameter int D = 160
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                         i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                         o_rdata
);

    logic [W-1:0] r_mem [D];

    // Write one word, read one word with registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hw/rtl/sms_dp.sv
module sms_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sms_pkg::t_in     i_in_data,
    input  logic             i_out_ready,
    input  sms_pkg::t_cmd    i_cmd,
    output sms_pkg::t_status o_status,
    output logic             o_out_valid,
    output sms_pkg::t_out    o_out_data
);
    import sms_pkg::*;

    t_in                  r_item;
    logic [DEPTH-1:0]     r_valid;
    logic [AW-1:0]        r_addr;
    logic                 r_pend;
    logic [AW-1:0]        r_pend_addr;
    logic                 r_found;
    logic signed [DW-1:0] r_best;
    logic [AW-1:0]        r_best_addr;
    logic signed [DW-1:0] r_res_value;
    logic                 r_res_hit;
    logic                 r_out_valid;
    t_out                 r_out;

    logic [LINW-1:0]      w_lin;
    logic [AW-1:0]        w_idx;
    logic                 w_in_range;
    logic                 w_cell_hit;
    logic                 w_wr_en;
    logic [AW-1:0]        w_raddr;
    logic signed [DW-1:0] w_rdata;
    logic                 w_take;

    // Decode cell position of the held transaction
    assign w_lin      = LINW'(r_item.row) * LINW'(COLS) + LINW'(r_item.column);
    assign w_idx      = w_lin[AW-1:0];
    assign w_in_range = ({1'b0, r_item.row} < 5'(ROWS)) && ({1'b0, r_item.column} < 5'(COLS));
    assign w_cell_hit = w_in_range && r_valid[w_idx];
    assign w_wr_en    = i_cmd.do_write && w_in_range && (r_item.value != '0);
    assign w_raddr    = i_cmd.scan_step ? r_addr : w_idx;

    sms_ram #(
        .W(DW),
        .D(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_wr_en),
        .i_waddr(w_idx),
        .i_wdata(r_item.value),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Keep the first largest entry seen so far
    assign w_take = r_pend && r_valid[r_pend_addr] && (!r_found || (w_rdata > r_best));

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
    end

    // Track occupied cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_wr_en) begin
                r_valid[w_idx] <= 1'b1;
            end
            if (i_cmd.finish_lookup && r_item.action == ACT_REMOVE && w_in_range) begin
                r_valid[w_idx] <= 1'b0;
            end
            if (i_cmd.dmax_finish && r_found) begin
                r_valid[r_best_addr] <= 1'b0;
            end
        end
    end

    // Advance the scan and compare one word per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_addr  <= '0;
        end else if (i_cmd.scan_start) begin
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_addr  <= '0;
        end else begin
            if (w_take) begin
                r_found     <= 1'b1;
                r_best      <= w_rdata;
                r_best_addr <= r_pend_addr;
            end
            if (i_cmd.scan_step) begin
                r_pend      <= 1'b1;
                r_pend_addr <= r_addr;
                r_addr      <= r_addr + 1'b1;
            end else if (i_cmd.scan_drain) begin
                r_pend <= 1'b0;
            end
        end
    end

    // Form the result of the transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write) begin
            r_res_value <= '0;
            r_res_hit   <= 1'b0;
        end else if (i_cmd.finish_lookup) begin
            r_res_value <= w_cell_hit ? w_rdata : '0;
            r_res_hit   <= w_cell_hit;
        end else if (i_cmd.dmax_finish) begin
            r_res_value <= r_found ? r_best : '0;
            r_res_hit   <= r_found;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_out) begin
            r_out.result_value <= r_res_value;
            r_out.hit          <= r_res_hit;
        end
    end

    assign o_status.action    = r_item.action;
    assign o_status.scan_last = (r_addr == AW'(DEPTH - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

endmodule

### hw/rtl/sms_ctrl.sv
module sms_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sms_pkg::t_status i_status,
    output sms_pkg::t_cmd    o_cmd
);
    import sms_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_LOOKUP   = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_DRAIN    = 3'd4;
    localparam logic [2:0] S_DMAX_END = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Sequence one transaction at a time
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.action)
                    ACT_WRITE: begin
                        o_cmd.do_write = 1'b1;
                        n_state        = S_FINISH;
                    end
                    ACT_REMOVE, ACT_READ: begin
                        n_state = S_LOOKUP;
                    end
                    ACT_DMAX: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_LOOKUP: begin
                o_cmd.finish_lookup = 1'b1;
                n_state             = S_FINISH;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.scan_drain = 1'b1;
                n_state          = S_DMAX_END;
            end
            S_DMAX_END: begin
                o_cmd.dmax_finish = 1'b1;
                n_state           = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.push_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/sparse_matrix_store_top.sv
// Sparse matrix store: ROWS x COLS signed 32-bit cells, zero meaning empty.
// Input channel i_in_valid / o_in_ready carries one transaction: action
// (write, remove, read, delete largest), row, column and value. Output
// channel o_out_valid / i_out_ready returns exactly one result per input:
// result_value and hit.
// Write, remove and read each make one RAM access before the result moves to
// the output register. Delete largest reads every cell once through the single
// RAM read port before its result appears.
// One transaction is in work at a time; the next is accepted the cycle after
// the result has moved to the output register, also while that result still
// waits for i_out_ready.
// When the receiver stalls, the result holds in the output register and a
// further finished result waits inside until the register frees.
// Reset (i_rst_n low, synchronous) empties every cell at once through the
// per-cell occupancy flags and drops any pending result.
module sparse_matrix_store_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sms_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sms_pkg::t_out o_out_data
);
    import sms_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    sms_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    sms_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_out_ready(i_out_ready),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

    // A hit always carries a stored, hence nonzero, value
    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.hit == (o_out_data.result_value != '0)))
        else $error("hit flag disagrees with result value");

    // Only one transaction is in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a transaction is in work");

    // A finished result never enters an occupied output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push_out |-> (!o_out_valid || i_out_ready))
        else $error("result pushed over a pending result");

    // Reset leaves the output empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

### sim/sms_checker.sv
module sms_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  sms_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  sms_pkg::t_out i_out_data,
    output int            o_err_count,
    output int            o_pending
);

    import sms_pkg::*;

    // Shadow copy of the matrix, zero meaning empty
    logic signed [DW-1:0] cell_shadow [DEPTH];
    // Results still owed by the block, oldest first
    t_out                 owed_results [$];
    int                   err_count = 0;

    // Apply one transaction to the shadow matrix and return its result
    function automatic t_out apply_action(input t_in item);
        t_out        res;
        logic        in_range;
        int unsigned idx;
        int          best;
        res      = '0;
        in_range = (item.row < ROWS) && (item.column < COLS);
        idx      = item.row * COLS + item.column;
        best     = -1;
        case (item.action)
            ACT_WRITE: begin
                if (in_range && item.value != 0)
                    cell_shadow[idx] = item.value;
            end
            ACT_REMOVE, ACT_READ: begin
                if (in_range && cell_shadow[idx] != 0) begin
                    res.result_value = cell_shadow[idx];
                    res.hit          = 1'b1;
                    if (item.action == ACT_REMOVE)
                        cell_shadow[idx] = '0;
                end
            end
            default: begin
                // Row-major scan; strict compare keeps the first of equal maxima
                for (int i = 0; i < DEPTH; i++) begin
                    if (cell_shadow[i] != 0 && (best < 0 || cell_shadow[i] > cell_shadow[best]))
                        best = i;
                end
                if (best >= 0) begin
                    res.result_value  = cell_shadow[best];
                    res.hit           = 1'b1;
                    cell_shadow[best] = '0;
                end
            end
        endcase
        return res;
    endfunction

    // Count a mismatch; print only the first few
    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Compare delivered results, then record the result owed for a new transaction
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            foreach (cell_shadow[i]) cell_shadow[i] = '0;
            owed_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    note_error($sformatf("unexpected result value=%h hit=%b",
                                         i_out_data.result_value, i_out_data.hit));
                end else begin
                    want = owed_results.pop_front();
                    if (i_out_data.result_value !== want.result_value)
                        note_error($sformatf("result_value expected %h, got %h",
                                             want.result_value, i_out_data.result_value));
                    if (i_out_data.hit !== want.hit)
                        note_error($sformatf("hit expected %b, got %b",
                                             want.hit, i_out_data.hit));
                end
            end
            if (i_in_valid && i_in_ready)
                owed_results.push_back(apply_action(i_in_data));
        end
        o_pending   <= owed_results.size();
        o_err_count <= err_count;
    end

endmodule

### sim/tb_top.sv
module tb_top;

    import sms_pkg::*;

    localparam int RANDOM_ITEMS   = 450;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 200;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    int   err_count;
    int   pending;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   sent_total  = 0;
    int   sent_by_action [4] = '{default: 0};

    sparse_matrix_store_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    sms_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always #5 clk = ~clk;

    // Receiver: random stalls, or a long hold-off when requested
    always @(posedge clk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offer one transaction, with optional idle cycles first; hold until accepted
    task automatic send_item(input t_in item);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_total++;
        sent_by_action[item.action]++;
    endtask

    task automatic issue(input logic [1:0] action, input int unsigned row,
                         input int unsigned column, input logic [DW-1:0] value);
        t_in item;
        item.action = action;
        item.row    = row[3:0];
        item.column = column[3:0];
        item.value  = value;
        send_item(item);
    endtask

    // Random transaction: addresses favor a small corner so reads and removes hit
    function automatic t_in random_item();
        t_in         item;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)      item.action = ACT_WRITE;
        else if (pick < 55) item.action = ACT_REMOVE;
        else if (pick < 80) item.action = ACT_READ;
        else                item.action = ACT_DMAX;
        pick = $urandom_range(99);
        if (pick < 50) begin
            item.row    = 4'($urandom_range(2));
            item.column = 4'($urandom_range(3));
        end else if (pick < 90) begin
            item.row    = 4'($urandom_range(ROWS - 1));
            item.column = 4'($urandom_range(COLS - 1));
        end else begin
            item.row    = 4'($urandom_range(15, ROWS));
            item.column = 4'($urandom_range(15));
        end
        // Small values give ties and negatives; extremes test the signed compare
        pick = $urandom_range(99);
        if (pick < 10) begin
            item.value = '0;
        end else if (pick < 45) begin
            item.value = DW'($signed($urandom_range(14)) - 7);
        end else if (pick < 55) begin
            case ($urandom_range(3))
                0:       item.value = 32'h7FFF_FFFF;
                1:       item.value = 32'h8000_0000;
                2:       item.value = 32'h0000_0001;
                default: item.value = 32'hFFFF_FFFF;
            endcase
        end else begin
            item.value = $urandom;
        end
        return item;
    endfunction

    initial begin
        automatic int idle_tab  [4] = '{0, 54, 0, 15};
        automatic int stall_tab [4] = '{0, 0, 54, 15};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty matrix, extremes, ignored writes, ties, drain to empty
        issue(ACT_DMAX,   0,  0, 32'h0);
        issue(ACT_READ,   0,  0, 32'h0);
        issue(ACT_REMOVE, 3,  3, 32'h0);
        issue(ACT_WRITE,  0,  0, 32'h7FFF_FFFF);
        issue(ACT_WRITE,  9, 15, 32'h8000_0000);
        issue(ACT_WRITE,  1,  1, 32'h0);
        issue(ACT_READ,   1,  1, 32'h0);
        issue(ACT_WRITE, 15, 15, 32'h1234_5678);
        issue(ACT_READ,  15, 15, 32'h0);
        issue(ACT_REMOVE, 10, 0, 32'h0);
        issue(ACT_WRITE,  2,  3, 32'h0000_0005);
        issue(ACT_WRITE,  4,  1, 32'h0000_0005);
        issue(ACT_WRITE,  3,  0, 32'hFFFF_FFFF);
        issue(ACT_WRITE,  3,  0, 32'hFFFF_FFF9);
        issue(ACT_READ,   0,  0, 32'h0);
        issue(ACT_READ,   9, 15, 32'h0);
        issue(ACT_DMAX,   0,  0, 32'h0);
        issue(ACT_DMAX,   0,  0, 32'h0);
        issue(ACT_READ,   2,  3, 32'h0);
        issue(ACT_READ,   4,  1, 32'h0);
        issue(ACT_REMOVE, 4,  1, 32'h0);
        issue(ACT_DMAX,   0,  0, 32'h0);
        issue(ACT_DMAX,   0,  0, 32'h0);
        issue(ACT_DMAX,   0,  0, 32'h0);

        // Random: four idling phases, the first with a long receiver hold-off
        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            if (p == 0)
                hold_req <= 1'b1;
            repeat (RANDOM_ITEMS / 4) send_item(random_item());
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then watch for anything extra
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d transactions: %0d writes, %0d removes, %0d reads, %0d delete-max",
                 sent_total, sent_by_action[ACT_WRITE], sent_by_action[ACT_REMOVE],
                 sent_by_action[ACT_READ], sent_by_action[ACT_DMAX]);
        $display("Idling phases: none, sender 54%%, receiver 54%%, both 15%%; one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Mismatches: %0d", err_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sparse_matrix_store_top.f
hw/rtl/sms_pkg.sv
hw/rtl/sms_ram.sv
hw/rtl/sms_dp.sv
hw/rtl/sms_ctrl.sv
hw/rtl/sparse_matrix_store_top.sv
sim/sms_checker.sv
sim/tb_top.sv
